// ----- design/mexp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the modular exponentiation unit: widths, register indexes,
// controller state encoding and the multiplier command/status structs.
// No dependencies.
package mexp_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REDUCE = 5'b00010,
      S_SQUARE = 5'b00100,
      S_MULT   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   typedef struct packed {
      logic start;
   } mul_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// ----- design/modular_exponentiation_unit.sv -----
`timescale 1ns / 1ps
// Modular exponentiation unit: power_mod = base_value ^ exponent mod modulus.
// Depends on mexp_pkg and mexp_mulmod.
//
// Usage:
//   csr_*  : write port; index 0 = exponent, index 1 = modulus. Write only
//            while the block is idle. Other indexes are ignored.
//   req_*  : one base_value per transfer; taken only while no item is in work.
//   rsp_*  : one power_mod per request, held in an output register.
// Each item first reduces the base mod N, then walks all WIDTH exponent bits
// MSB first: a modular square per bit plus a modular multiply per set bit.
// Every modular product runs on one bit-serial multiplier; a modulus of 0
// skips it and answers 0. One item at a time: no new request is taken
// until the result of the last one has left the work states.
// A new request is taken while a finished result still waits in the output
// register; when the receiver stalls, a second result waits inside until the
// output register drains. Reset clears all control state, sets exponent to 0
// and modulus to 1, and drops any pending result.
module modular_exponentiation_unit #(
   parameter int WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [mexp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]         csr_wdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [mexp_pkg::DATA_WIDTH-1:0]         req_tdata,  // [31:0] base_value
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [mexp_pkg::DATA_WIDTH-1:0]         rsp_tdata   // [31:0] power_mod
);
   import mexp_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0] exponent_ff, modulus_ff;
   logic [WIDTH-1:0]      exp_ff, exp_in;
   logic [WIDTH-1:0]      base_ff, base_in;
   logic [WIDTH-1:0]      acc_ff, acc_in;
   logic [CW-1:0]         left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic                  rsp_load;

   logic [WIDTH+DATA_WIDTH-1:0] mod_ext, exp_ext, base_ext, acc_ext;
   logic [WIDTH-1:0]            m_w, e_w, base_w, acc_init;
   logic                        last_bit;

   mul_cmd_type      mul_cmd;
   mul_stat_type     mul_stat;
   logic [WIDTH-1:0] mul_a, mul_b, mul_prod;

   mexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (m_w),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   // fit 32-bit fields to the datapath width
   assign mod_ext  = {{WIDTH{1'b0}}, modulus_ff};
   assign exp_ext  = {{WIDTH{1'b0}}, exponent_ff};
   assign base_ext = {{WIDTH{1'b0}}, req_tdata};
   assign acc_ext  = {{DATA_WIDTH{1'b0}}, acc_ff};
   assign m_w      = mod_ext[WIDTH-1:0];
   assign e_w      = exp_ext[WIDTH-1:0];
   assign base_w   = base_ext[WIDTH-1:0];
   assign acc_init = (m_w == WIDTH'(1)) ? '0 : WIDTH'(1);
   assign last_bit = (left_ff == CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= '0;
         modulus_ff  <= DATA_WIDTH'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXPONENT: exponent_ff <= csr_wdata;
            CSR_MODULUS:  modulus_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      left_in       = left_ff;
      mul_cmd.start = 1'b0;
      mul_a         = mul_prod;
      mul_b         = mul_prod;
      rsp_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               exp_in  = e_w;
               left_in = CW'(WIDTH);
               if (m_w == '0) begin
                  acc_in   = '0;
                  state_in = S_DONE;
               end else begin
                  mul_cmd.start = 1'b1;
                  mul_a         = WIDTH'(1);
                  mul_b         = base_w;
                  state_in      = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mul_stat.done) begin
               base_in       = mul_prod;
               acc_in        = acc_init;
               mul_cmd.start = 1'b1;
               mul_a         = acc_init;
               mul_b         = acc_init;
               state_in      = S_SQUARE;
            end
         end
         S_SQUARE, S_MULT: begin
            if (mul_stat.done) begin
               acc_in = mul_prod;
               if (state_ff == S_SQUARE && exp_ff[WIDTH-1]) begin
                  mul_cmd.start = 1'b1;
                  mul_b         = base_ff;
                  state_in      = S_MULT;
               end else begin
                  exp_in  = {exp_ff[WIDTH-2:0], 1'b0};
                  left_in = left_ff - CW'(1);
                  if (last_bit) begin
                     state_in = S_DONE;
                  end else begin
                     mul_cmd.start = 1'b1;
                     state_in      = S_SQUARE;
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      if (rsp_load) begin
         rsp_data_ff <= acc_ext[DATA_WIDTH-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_done_in_work: assert property (@(posedge clock) disable iff (reset)
      mul_stat.done |-> (state_ff == S_REDUCE || state_ff == S_SQUARE || state_ff == S_MULT))
      else $error("multiplier finished outside a work state");

   a_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_cmd.start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mul_stat.busy)
      else $error("multiplier busy while controller idle");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_tvalid)
      else $error("result load lost");
`endif

endmodule

// ----- design/mexp_mulmod.sv -----
`timescale 1ns / 1ps
// Bit-serial modular multiplier: product = op_a * op_b mod modulus,
// one multiplier bit per cycle, MSB first (interleaved double-and-add).
// Depends on mexp_pkg. Needs op_a < modulus or op_a == 1.
module mexp_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mexp_pkg::mul_cmd_type cmd,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   input  logic [WIDTH-1:0]     modulus,
   output mexp_pkg::mul_stat_type stat,
   output logic [WIDTH-1:0]     product
);
   import mexp_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff;
   logic [WIDTH-1:0] b_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH+1:0] sum, mod1, mod2, diff1, diff2;

   // t = 2*acc + bit*a < 3*m, reduced by m or 2*m
   always_comb begin
      sum   = {1'b0, acc_ff, 1'b0} + {2'b00, a_ff & {WIDTH{b_ff[WIDTH-1]}}};
      mod1  = {2'b00, modulus};
      mod2  = {1'b0, modulus, 1'b0};
      diff1 = sum - mod1;
      diff2 = sum - mod2;
      if (sum >= mod2) begin
         acc_in = diff2[WIDTH-1:0];
      end else if (sum >= mod1) begin
         acc_in = diff1[WIDTH-1:0];
      end else begin
         acc_in = sum[WIDTH-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= {b_ff[WIDTH-2:0], 1'b0};
         acc_ff <= acc_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule
